[hw/rtl/vfpe_pkg.sv]
// ----------------------------------------------------------------------------
// vfpe_pkg: shared types and widths
// Widths of the vertex-face penalty energy datapath, the item, side-band and
// result records, and the configuration register indexes.
// ----------------------------------------------------------------------------
package vfpe_pkg;

    // coordinate and edge widths
    localparam int CW   = 24;   // input coordinate
    localparam int DW   = 25;   // coordinate difference
    localparam int PW   = 50;   // cross product term
    localparam int NW   = 51;   // raw normal component
    localparam int NMW  = 30;   // scaled normal magnitude
    localparam int SNW  = 31;   // scaled normal, signed
    localparam int NORM_BITS = 30;
    localparam int SQW  = 60;   // squared scaled component
    localparam int PDW  = 55;   // normal times offset term
    localparam int NNW  = 62;   // squared normal length
    localparam int DOTW = 57;   // dot product, signed
    localparam int DMW  = 56;   // dot product magnitude
    localparam int LENW = 31;   // normal length
    localparam int RW   = 63;   // root remainder
    localparam int QW   = 27;   // distance magnitude
    localparam int DRW  = 58;   // divider compare width
    localparam int DSW  = 28;   // signed distance
    localparam int LW   = 29;   // distance minus offset
    localparam int LMW  = 28;   // its magnitude
    localparam int L2W  = 56;   // squared length
    localparam int MUW  = 32;   // stiffness
    localparam int MPW  = 88;   // stiffness times squared length
    localparam int EW   = 48;   // energy

    // configuration port
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_STIFFNESS   = 1'b0;
    localparam logic [CFG_IW-1:0] REG_REST_OFFSET = 1'b1;
    localparam logic [MUW-1:0]    STIFFNESS_RESET = 32'd65536;

    typedef struct packed {
        logic signed [CW-1:0] p_x;
        logic signed [CW-1:0] p_y;
        logic signed [CW-1:0] p_z;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
    } item_t;

    // travels beside the root unit
    typedef struct packed {
        logic           degen;
        logic           dot_neg;
        logic [DMW-1:0] dot_mag;
    } side_t;

    typedef struct packed {
        logic [EW-1:0] energy;
        logic          degenerate;
    } result_t;

    function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
        return DW'(x) - DW'(y);
    endfunction

endpackage

[hw/rtl/vfpe_if.sv]
// ----------------------------------------------------------------------------
// vfpe_if: item and result channels
// Valid/ready channels of the penalty energy block with their payloads.
// ----------------------------------------------------------------------------
interface vfpe_item_if;
    import vfpe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
    logic signed [CW-1:0] p_z;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;

    modport source (output valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                    c_x, c_y, c_z, input ready);
    modport sink (input valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, output ready);
endinterface

interface vfpe_result_if;
    import vfpe_pkg::*;
    logic          valid;
    logic          ready;
    logic [EW-1:0] energy;
    logic          degenerate;

    modport source (output valid, energy, degenerate, input ready);
    modport sink (input valid, energy, degenerate, output ready);
endinterface

[hw/rtl/vfpe_front.sv]
// ----------------------------------------------------------------------------
// vfpe_front: normal, scaling and dot product
// Eleven stages: edges, cross product, magnitudes, leading-one search,
// normalizing shift, squares and dot terms, sums, dot magnitude.
// ----------------------------------------------------------------------------
module vfpe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  vfpe_pkg::item_t        in_item,
    output logic                   out_valid,
    output logic [vfpe_pkg::NNW-1:0] out_nn,
    output vfpe_pkg::side_t        out_side
);
    import vfpe_pkg::*;

    localparam int FS = 11;
    localparam int NCH = 7;     // 8-bit chunks over the padded normal

    logic [FS-1:0]         v_reg;
    logic signed [DW-1:0]  e1_reg [3];
    logic signed [DW-1:0]  e2_reg [3];
    logic signed [DW-1:0]  t_reg [1:8][3];
    logic signed [PW-1:0]  pr_reg [6];
    logic signed [NW-1:0]  n_reg [3];
    logic [NW-1:0]         mag_reg [4:7][3];
    logic                  neg_reg [4:8][3];
    logic [NW-1:0]         m_reg;
    logic [NCH-1:0]        flag_reg;
    logic [2:0]            pos_reg [NCH];
    logic                  lft_reg;
    logic [4:0]            up_reg;
    logic [4:0]            down_reg;
    logic                  degen_reg [7:11];
    logic [NMW-1:0]        nm_reg [3];
    logic [SQW-1:0]        sq_reg [3];
    logic signed [PDW-1:0] pd_reg [3];
    logic [NNW-1:0]        nn10_reg;
    logic [NNW-1:0]        nn11_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic                  dotneg_reg;
    logic [DMW-1:0]        dotmag_reg;

    logic [NW-1:0]         m_next;
    logic [NCH-1:0]        flag_next;
    logic [2:0]            pos_next [NCH];
    logic [5:0]            bl_next;
    logic [NMW-1:0]        nm_next [3];
    logic signed [SNW-1:0] ns_next [3];

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[FS-2:0], in_valid};
    end

    // max magnitude and per-chunk leading one
    always_comb
    begin
        logic [NCH*8-1:0] mp;
        logic [7:0]       ch;
        m_next = mag_reg[4][0];
        if (mag_reg[4][1] > m_next) m_next = mag_reg[4][1];
        if (mag_reg[4][2] > m_next) m_next = mag_reg[4][2];
        mp = {5'b0, m_reg};
        for (int c = 0; c < NCH; c++)
        begin
            ch = mp[c*8 +: 8];
            flag_next[c] = |ch;
            pos_next[c] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (ch[b])
                    pos_next[c] = 3'(b);
            end
        end
    end

    // bit length of the largest component
    always_comb
    begin
        bl_next = 6'd0;
        for (int c = 0; c < NCH; c++)
        begin
            if (flag_reg[c])
                bl_next = 6'(c * 8) + 6'(pos_reg[c]) + 6'd1;
        end
    end

    // normalizing shift and signed scaled normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (lft_reg)
                nm_next[i] = NMW'(mag_reg[7][i] << up_reg);
            else
                nm_next[i] = NMW'(mag_reg[7][i] >> down_reg);
            ns_next[i] = neg_reg[8][i] ? -signed'({1'b0, nm_reg[i]})
                                       : signed'({1'b0, nm_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edges
            e1_reg[0] <= diff(in_item.a_x, in_item.b_x);
            e1_reg[1] <= diff(in_item.a_y, in_item.b_y);
            e1_reg[2] <= diff(in_item.a_z, in_item.b_z);
            e2_reg[0] <= diff(in_item.c_x, in_item.b_x);
            e2_reg[1] <= diff(in_item.c_y, in_item.b_y);
            e2_reg[2] <= diff(in_item.c_z, in_item.b_z);
            t_reg[1][0] <= diff(in_item.p_x, in_item.b_x);
            t_reg[1][1] <= diff(in_item.p_y, in_item.b_y);
            t_reg[1][2] <= diff(in_item.p_z, in_item.b_z);
            for (int s = 2; s <= 8; s++)
                for (int i = 0; i < 3; i++)
                    t_reg[s][i] <= t_reg[s-1][i];
            // cross product terms
            pr_reg[0] <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
            pr_reg[1] <= PW'(e1_reg[2]) * PW'(e2_reg[1]);
            pr_reg[2] <= PW'(e1_reg[2]) * PW'(e2_reg[0]);
            pr_reg[3] <= PW'(e1_reg[0]) * PW'(e2_reg[2]);
            pr_reg[4] <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
            pr_reg[5] <= PW'(e1_reg[1]) * PW'(e2_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= NW'(pr_reg[2*i]) - NW'(pr_reg[2*i+1]);
                // magnitudes and signs
                neg_reg[4][i] <= n_reg[i][NW-1];
                mag_reg[4][i] <= n_reg[i][NW-1] ? unsigned'(-n_reg[i])
                                                : unsigned'(n_reg[i]);
                for (int s = 5; s <= 7; s++)
                    mag_reg[s][i] <= mag_reg[s-1][i];
                for (int s = 5; s <= 8; s++)
                    neg_reg[s][i] <= neg_reg[s-1][i];
                nm_reg[i] <= nm_next[i];
                sq_reg[i] <= SQW'(nm_reg[i]) * SQW'(nm_reg[i]);
                pd_reg[i] <= PDW'(ns_next[i]) * PDW'(t_reg[8][i]);
            end
            m_reg <= m_next;
            flag_reg <= flag_next;
            for (int c = 0; c < NCH; c++)
                pos_reg[c] <= pos_next[c];
            // shift direction and amount
            lft_reg <= (bl_next <= 6'(NORM_BITS));
            up_reg <= 5'(6'(NORM_BITS) - bl_next);
            down_reg <= 5'(bl_next - 6'(NORM_BITS));
            degen_reg[7] <= ~|flag_reg;
            for (int s = 8; s <= 11; s++)
                degen_reg[s] <= degen_reg[s-1];
            // sums
            nn10_reg <= NNW'(sq_reg[0]) + NNW'(sq_reg[1]) + NNW'(sq_reg[2]);
            dot_reg <= DOTW'(pd_reg[0]) + DOTW'(pd_reg[1]) + DOTW'(pd_reg[2]);
            nn11_reg <= nn10_reg;
            dotneg_reg <= dot_reg[DOTW-1];
            dotmag_reg <= DMW'(dot_reg[DOTW-1] ? -dot_reg : dot_reg);
        end
    end

    assign out_valid        = v_reg[FS-1];
    assign out_nn           = nn11_reg;
    assign out_side.degen   = degen_reg[11];
    assign out_side.dot_neg = dotneg_reg;
    assign out_side.dot_mag = dotmag_reg;

endmodule

[hw/rtl/vfpe_sqrt.sv]
// ----------------------------------------------------------------------------
// vfpe_sqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence, floor of the root.
// ----------------------------------------------------------------------------
module vfpe_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [vfpe_pkg::NNW-1:0]  in_nn,
    input  vfpe_pkg::side_t           in_side,
    output logic                      out_valid,
    output logic [vfpe_pkg::LENW-1:0] out_len,
    output vfpe_pkg::side_t           out_side
);
    import vfpe_pkg::*;

    localparam int ST = LENW;

    logic [ST-1:0]   v_reg;
    logic [RW-1:0]   rem_reg [ST];
    logic [LENW-1:0] root_reg [ST];
    side_t           side_reg [ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST-2:0], in_valid};
    end

    for (genvar s = 0; s < ST; s++)
    begin : g_step
        logic [RW-1:0]   rem_in;
        logic [RW-1:0]   trial;
        logic [LENW-1:0] root_in;
        side_t           side_in;

        if (s == 0)
        begin : g_head
            assign rem_in  = RW'(in_nn);
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_tail
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // (root + 2^b)^2 - root^2
        assign trial = (RW'(root_in) << (ST - s)) + (RW'(1) << (2 * (ST - 1 - s)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_in;
                if (rem_in >= trial)
                begin
                    rem_reg[s]  <= rem_in - trial;
                    root_reg[s] <= root_in | (LENW'(1) << (ST - 1 - s));
                end
                else
                begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign out_valid = v_reg[ST-1];
    assign out_len   = root_reg[ST-1];
    assign out_side  = side_reg[ST-1];

endmodule

[hw/rtl/vfpe_div.sv]
// ----------------------------------------------------------------------------
// vfpe_div: pipelined restoring divider
// Dot magnitude over normal length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vfpe_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [vfpe_pkg::LENW-1:0] in_len,
    input  vfpe_pkg::side_t           in_side,
    output logic                      out_valid,
    output logic [vfpe_pkg::QW-1:0]   out_quo,
    output logic                      out_neg,
    output logic                      out_degen
);
    import vfpe_pkg::*;

    localparam int ST = QW;

    logic [ST-1:0]   v_reg;
    logic [DMW-1:0]  rem_reg [ST];
    logic [QW-1:0]   quo_reg [ST];
    logic [LENW-1:0] len_reg [ST];
    logic            neg_reg [ST];
    logic            degen_reg [ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST-2:0], in_valid};
    end

    for (genvar s = 0; s < ST; s++)
    begin : g_step
        logic [DMW-1:0]  rem_in;
        logic [QW-1:0]   quo_in;
        logic [LENW-1:0] len_in;
        logic            neg_in;
        logic            degen_in;
        logic [DRW-1:0]  dv;

        if (s == 0)
        begin : g_head
            assign rem_in   = in_side.dot_mag;
            assign quo_in   = '0;
            assign len_in   = in_len;
            assign neg_in   = in_side.dot_neg;
            assign degen_in = in_side.degen;
        end
        else
        begin : g_tail
            assign rem_in   = rem_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign len_in   = len_reg[s-1];
            assign neg_in   = neg_reg[s-1];
            assign degen_in = degen_reg[s-1];
        end

        assign dv = DRW'(len_in) << (ST - 1 - s);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[s]   <= len_in;
                neg_reg[s]   <= neg_in;
                degen_reg[s] <= degen_in;
                if (DRW'(rem_in) >= dv)
                begin
                    rem_reg[s] <= DMW'(DRW'(rem_in) - dv);
                    quo_reg[s] <= quo_in | (QW'(1) << (ST - 1 - s));
                end
                else
                begin
                    rem_reg[s] <= rem_in;
                    quo_reg[s] <= quo_in;
                end
            end
        end
    end

    assign out_valid = v_reg[ST-1];
    assign out_quo   = quo_reg[ST-1];
    assign out_neg   = neg_reg[ST-1];
    assign out_degen = degen_reg[ST-1];

endmodule

[hw/rtl/vfpe_back.sv]
// ----------------------------------------------------------------------------
// vfpe_back: offset, square and stiffness scaling
// Seven stages from the signed distance to the saturated energy.
// ----------------------------------------------------------------------------
module vfpe_back #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [vfpe_pkg::QW-1:0]       in_quo,
    input  logic                          in_neg,
    input  logic                          in_degen,
    input  logic [vfpe_pkg::MUW-1:0]      stiffness,
    input  logic signed [vfpe_pkg::CW-1:0] rest_offset,
    output logic                          out_valid,
    output vfpe_pkg::result_t             out_res
);
    import vfpe_pkg::*;

    localparam int BS = 7;
    localparam int SH = 16 + COORD_FRAC_BITS;

    logic [BS-1:0]         v_reg;
    logic                  degen_reg [1:6];
    logic signed [DSW-1:0] d_reg;
    logic signed [LW-1:0]  l_reg;
    logic [LMW-1:0]        lm_reg;
    logic [L2W-1:0]        l2_reg;
    logic [63:0]           lo_reg;
    logic [55:0]           hi_reg;
    logic [MPW-1:0]        tot_reg;
    result_t               res_reg;
    result_t               res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[BS-2:0], in_valid};
    end

    // saturate and scale down
    always_comb
    begin
        res_next.degenerate = degen_reg[6];
        if (degen_reg[6])
            res_next.energy = '0;
        else if ((tot_reg >> (SH + EW)) != '0)
            res_next.energy = '1;
        else
            res_next.energy = tot_reg[SH +: EW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg[1] <= in_degen;
            for (int s = 2; s <= 6; s++)
                degen_reg[s] <= degen_reg[s-1];
            d_reg  <= in_neg ? -signed'({1'b0, in_quo}) : signed'({1'b0, in_quo});
            l_reg  <= LW'(d_reg) - LW'(rest_offset);
            lm_reg <= LMW'(l_reg[LW-1] ? -l_reg : l_reg);
            l2_reg <= L2W'(lm_reg) * L2W'(lm_reg);
            // split product, low and high halves of the squared length
            lo_reg <= 64'(stiffness) * 64'(l2_reg[31:0]);
            hi_reg <= 56'(stiffness) * 56'(l2_reg[L2W-1:32]);
            tot_reg <= MPW'(lo_reg) + (MPW'(hi_reg) << 32);
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[BS-1];
    assign out_res   = res_reg;

endmodule

[hw/rtl/vertex_face_penalty_energy.sv]
// ----------------------------------------------------------------------------
// vertex_face_penalty_energy: point to face plane penalty energy
// Signed distance of a vertex from a triangle plane, minus a rest offset,
// squared and scaled by a stiffness, with a zero-area face flag.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready sink, one vertex and three face corners per transfer.
//   result : valid/ready source, energy and degenerate flag per item, in order.
//   cfg    : write port, index 0 stiffness (Q16.16), index 1 rest offset.
//            Write only while no item is in flight.
// Path: a result passes 11 front stages, 31 root stages, 27 divider stages,
//   7 back stages, then the two-entry output buffer.
// Throughput: one item per cycle while the output buffer has room; every stage is a single register step.
// Stall: the whole pipeline holds while the output buffer is full; with
//   one result waiting, new items still flow in. item.ready comes from a
//   register, not from result.ready.
// Reset: pipeline and buffer empty, stiffness 1.0, rest offset 0.
// ----------------------------------------------------------------------------
module vertex_face_penalty_energy #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vfpe_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [vfpe_pkg::MUW-1:0]      cfg_wdata,
    vfpe_item_if.sink                     item,
    vfpe_result_if.source                 result
);
    import vfpe_pkg::*;

    logic [MUW-1:0]       stiffness_reg;
    logic signed [CW-1:0] rest_offset_reg;

    item_t           item_in;
    logic            pipe_en;
    logic            fr_valid;
    logic [NNW-1:0]  fr_nn;
    side_t           fr_side;
    logic            sq_valid;
    logic [LENW-1:0] sq_len;
    side_t           sq_side;
    logic            dv_valid;
    logic [QW-1:0]   dv_quo;
    logic            dv_neg;
    logic            dv_degen;
    logic            back_valid;
    result_t         back_res;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       push;
    logic       pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= STIFFNESS_RESET;
            rest_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STIFFNESS:   stiffness_reg <= cfg_wdata;
                REG_REST_OFFSET: rest_offset_reg <= signed'(cfg_wdata[CW-1:0]);
                default: ;
            endcase
        end
    end

    assign item_in = '{p_x: item.p_x, p_y: item.p_y, p_z: item.p_z,
                       a_x: item.a_x, a_y: item.a_y, a_z: item.a_z,
                       b_x: item.b_x, b_y: item.b_y, b_z: item.b_z,
                       c_x: item.c_x, c_y: item.c_y, c_z: item.c_z};

    // pipeline advances while the output buffer has room
    assign pipe_en    = (cnt_reg != 2'd2);
    assign item.ready = pipe_en;

    vfpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (item.valid),
        .in_item   (item_in),
        .out_valid (fr_valid),
        .out_nn    (fr_nn),
        .out_side  (fr_side)
    );

    vfpe_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (fr_valid),
        .in_nn     (fr_nn),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_side  (sq_side)
    );

    vfpe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (sq_valid),
        .in_len    (sq_len),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg),
        .out_degen (dv_degen)
    );

    vfpe_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (dv_valid),
        .in_quo      (dv_quo),
        .in_neg      (dv_neg),
        .in_degen    (dv_degen),
        .stiffness   (stiffness_reg),
        .rest_offset (rest_offset_reg),
        .out_valid   (back_valid),
        .out_res     (back_res)
    );

    // two-entry output buffer
    assign push = back_valid & pipe_en;
    assign pop  = result.valid & result.ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    slot0_next = back_res;
                else
                    slot1_next = back_res;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                    slot0_next = back_res;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = back_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign result.valid      = (cnt_reg != 2'd0);
    assign result.energy     = slot0_reg.energy;
    assign result.degenerate = slot0_reg.degenerate;

    // checks
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |-> (result.energy == '0))
        else $error("degenerate face with nonzero energy");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!pipe_en && back_valid) |=> back_valid)
        else $error("pipeline output lost during stall");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: vertex-face penalty energy testbench
// Drives vertex/face items through the valid/ready channel, predicts the
// penalty energy and degenerate flag of each transfer in fixed point, and
// compares every result in order. Covers directed corner items, several
// stiffness and rest offset settings, and random traffic with idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import vfpe_pkg::*;

    localparam int  CLK_PERIOD  = 10;
    localparam int  DRAIN_WAIT  = 100;      // well beyond the depth of the pipeline
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint unsigned ENERGY_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int COORD_FRAC_BITS_TB = 16;

    logic clk;
    logic rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [MUW-1:0]      cfg_wdata;

    vfpe_item_if   item_ch ();
    vfpe_result_if res_ch ();

    vertex_face_penalty_energy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // predictor copy of the registers
    logic [MUW-1:0]       mu;
    logic signed [CW-1:0] eps;

    result_t energy_q[$];
    int      src_idle;
    int      snk_idle;
    int      mismatches = 0;
    int      cycles = 0;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("vertex_face_penalty_energy test failed");
            $finish;
        end
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected energy and flag of one vertex/face pair
    function automatic result_t penalty_energy(input item_t it);
        longint p[3], a[3], b[3], c[3], e1[3], e2[3], t[3], n[3];
        longint unsigned mag, m, nn;
        longint dot, len, sdist, lsub;
        longint unsigned l2;
        logic [127:0] prod;
        int bl, up, down;
        result_t r;
        p = '{longint'(it.p_x), longint'(it.p_y), longint'(it.p_z)};
        a = '{longint'(it.a_x), longint'(it.a_y), longint'(it.a_z)};
        b = '{longint'(it.b_x), longint'(it.b_y), longint'(it.b_z)};
        c = '{longint'(it.c_x), longint'(it.c_y), longint'(it.c_z)};
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = a[i] - b[i];
            e2[i] = c[i] - b[i];
            t[i]  = p[i] - b[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = n[i] < 0 ? -n[i] : n[i];
            if (mag > m)
                m = mag;
        end
        if (m == 0)
        begin
            r.energy     = '0;
            r.degenerate = 1'b1;
            return r;
        end
        bl = 0;
        while (m != 0)
        begin
            bl++;
            m = m >> 1;
        end
        up   = bl < NORM_BITS ? NORM_BITS - bl : 0;
        down = bl > NORM_BITS ? bl - NORM_BITS : 0;
        // normalize so the largest magnitude sits in [2^29, 2^30)
        nn  = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = n[i] < 0 ? -n[i] : n[i];
            mag = up > 0 ? (mag << up) : (mag >> down);
            n[i] = n[i] < 0 ? -longint'(mag) : longint'(mag);
            nn  = nn + longint'(n[i] * n[i]);
            dot = dot + n[i] * t[i];
        end
        len   = longint'(floor_sqrt(nn));
        sdist = dot / len;
        lsub  = sdist - longint'(eps);
        l2    = lsub * lsub;
        prod = {96'd0, mu} * {64'd0, l2};
        prod = prod >> (16 + COORD_FRAC_BITS_TB);
        r.degenerate = 1'b0;
        r.energy     = (prod > ENERGY_MAX) ? EW'(ENERGY_MAX) : EW'(prod);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (energy_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result energy=%h degenerate=%b",
                             res_ch.energy, res_ch.degenerate);
            end
            else
            begin
                want = energy_q.pop_front();
                if (res_ch.energy !== want.energy || res_ch.degenerate !== want.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: energy exp %h got %h, degenerate exp %b got %b",
                                 want.energy, res_ch.energy, want.degenerate,
                                 res_ch.degenerate);
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    // one item transfer; called right after a rising edge
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.p_x <= it.p_x;  item_ch.p_y <= it.p_y;  item_ch.p_z <= it.p_z;
        item_ch.a_x <= it.a_x;  item_ch.a_y <= it.a_y;  item_ch.a_z <= it.a_z;
        item_ch.b_x <= it.b_x;  item_ch.b_y <= it.b_y;  item_ch.b_z <= it.b_z;
        item_ch.c_x <= it.c_x;  item_ch.c_y <= it.c_y;  item_ch.c_z <= it.c_z;
        do
            @(posedge clk);
        while (!item_ch.ready);
        energy_q.push_back(penalty_energy(it));
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (energy_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [MUW-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_STIFFNESS)
            mu = val;
        else
            eps = val[CW-1:0];
    endtask

    function automatic item_t pack_pts(input logic [CW-1:0] v[12]);
        item_t it;
        it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return it;
    endfunction

    // random pair: mostly proper triangles, some collinear, some noise
    function automatic item_t rand_item();
        logic [CW-1:0] v[12];
        int kind;
        int spread;
        int k;
        int base;
        int dv[3];
        kind   = $urandom_range(9);
        spread = 1 << $urandom_range(23, 4);
        for (int i = 0; i < 12; i++)
            v[i] = CW'($urandom);
        if (kind < 6)
        begin
            // vertex and triangle clustered around one point
            for (int j = 0; j < 3; j++)
            begin
                base = $signed(CW'($urandom)) / 2;
                for (int q = 0; q < 4; q++)
                    v[q * 3 + j] = CW'(base + $signed(CW'($urandom)) % (spread / 2));
            end
        end
        else if (kind < 8)
        begin
            // zero-area face: collinear or coincident corners
            k = int'($urandom_range(16)) - 8;
            for (int j = 0; j < 3; j++)
            begin
                base  = int'($urandom_range(2097152)) - 1048576;
                dv[j] = int'($urandom_range(2048)) - 1024;
                v[6 + j] = CW'(base);
                v[3 + j] = CW'(base + dv[j]);
                v[9 + j] = CW'(base + k * dv[j]);
            end
        end
        else if (kind == 8)
        begin
            for (int i = 0; i < 12; i++)
                v[i] = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        end
        return pack_pts(v);
    endfunction

    task automatic test_directed();
        logic [CW-1:0] v[12];
        // unit triangle in the z=0 plane, vertex above and below
        v = '{24'd0, 24'd0, 24'h010000, 24'h010000, 24'd0, 24'd0,
              24'd0, 24'd0, 24'd0, 24'd0, 24'h010000, 24'd0};
        send_item(pack_pts(v));
        v[2] = -24'sh030000;
        send_item(pack_pts(v));
        // vertex in the plane
        v[2] = 24'd0;
        send_item(pack_pts(v));
        // coincident corners and collinear corners
        v = '{24'd5, 24'd6, 24'd7, 24'h001000, 24'h001000, 24'h001000, 24'h001000,
              24'h001000, 24'h001000, 24'h001000, 24'h001000, 24'h001000};
        send_item(pack_pts(v));
        v = '{24'd0, 24'd0, 24'd0, 24'd1, 24'd2, 24'd3, 24'd0, 24'd0, 24'd0,
              -24'sd3, -24'sd6, -24'sd9};
        send_item(pack_pts(v));
        // full-scale extremes
        send_item('1);
        send_item('0);
        for (int i = 0; i < 12; i++)
            v[i] = (i % 2) ? 24'h7FFFFF : 24'h800000;
        send_item(pack_pts(v));
        for (int i = 0; i < 12; i++)
            v[i] = (i % 3 == 0) ? 24'h800000 : 24'h7FFFFF;
        send_item(pack_pts(v));
        // huge triangle, far vertex: saturates under the largest stiffness
        v = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
              24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000};
        send_item(pack_pts(v));
        // tiny triangle, normal needs left scaling
        v = '{24'h000100, 24'h000200, 24'h000300, 24'd1, 24'd0, 24'd0,
              24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0};
        send_item(pack_pts(v));
        for (int i = 0; i < 8; i++)
            send_item(rand_item());
    endtask

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        src_idle = s_idle;
        snk_idle = r_idle;
        for (int i = 0; i < count; i++)
        begin
            // occasionally hold off until the pipeline is empty
            if ($urandom_range(99) == 0)
                drain();
            // bursts with no source idling
            if (i % 60 < 10)
                src_idle = 0;
            else
                src_idle = s_idle;
            send_item(rand_item());
        end
        src_idle = s_idle;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        item_ch.valid = 1'b0;
        item_ch.p_x = '0;  item_ch.p_y = '0;  item_ch.p_z = '0;
        item_ch.a_x = '0;  item_ch.a_y = '0;  item_ch.a_z = '0;
        item_ch.b_x = '0;  item_ch.b_y = '0;  item_ch.b_z = '0;
        item_ch.c_x = '0;  item_ch.c_y = '0;  item_ch.c_z = '0;
        mu            = STIFFNESS_RESET;
        eps           = '0;
        src_idle      = 23;
        snk_idle      = 73;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        test_directed();
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(REG_REST_OFFSET, 32'h0080_0000);
        test_directed();
        write_reg(REG_STIFFNESS, 32'd0);
        write_reg(REG_REST_OFFSET, 32'h007F_FFFF);
        test_random(80, 23, 73);
        write_reg(REG_STIFFNESS, $urandom);
        write_reg(REG_REST_OFFSET, $urandom);
        test_random(140, 23, 73);
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(REG_REST_OFFSET, 32'h0000_0000);
        test_random(140, 73, 23);
        write_reg(REG_STIFFNESS, 32'd1);
        write_reg(REG_REST_OFFSET, 32'hFFFF_8000);
        test_random(70, 0, 0);
        write_reg(REG_STIFFNESS, $urandom_range(32'h0010_0000));
        write_reg(REG_REST_OFFSET, $urandom);
        test_random(70, 0, 0);

        drain();
        if (mismatches == 0 && energy_q.size() == 0)
            $display("vertex_face_penalty_energy test passed");
        else
            $display("vertex_face_penalty_energy test failed");
        $finish;
    end

endmodule
